[hdl/tlr_pkg.sv]
// Shared types and constants of the timecode linear remap block.
package tlr_pkg;

    // Milliseconds per timecode unit.
    localparam logic [21:0] MS_PER_HOUR = 22'd3600000;
    localparam logic [15:0] MS_PER_MIN  = 16'd60000;
    localparam logic [9:0]  MS_PER_SEC  = 10'd1000;

    // Largest time that a timecode holds: 999:59:59.999.
    localparam logic [31:0] MAX_MS = 32'd3599999999;

    // One quotient bit per divider stage for the 32-bit quotient.
    localparam int unsigned DIV_STAGES = 32;

    // Reciprocals for the split into hours, minutes and seconds.
    // The power-of-two part of each divisor is shifted out first.
    localparam logic [17:0] HOUR_RECIP = 18'd152709; // floor(2^32 / 28125)
    localparam logic [13:0] MIN_RECIP  = 14'd8947;   // floor(2^24 / 1875)
    localparam logic [9:0]  SEC_RECIP  = 10'd524;    // floor(2^16 / 125)

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PASS      = 3'd1,
        ST_ZERO_SPAN = 3'd2,
        ST_CLAMP     = 3'd3,
        ST_SAT       = 3'd4
    } status_t;

    typedef struct packed {
        logic [9:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] milli;
    } tc_t;

    // Values derived from the configuration registers.
    typedef struct packed {
        logic        pass;
        logic        zero_span;
        logic        dy_neg;
        logic        sx_neg;
        logic [31:0] dy_mag;
        logic [31:0] sx_mag;
        logic [31:0] src_start;
        logic [31:0] dst_start;
    } cfg_t;

    // Front end to divider.
    typedef struct packed {
        tc_t         tc;
        logic        dx_neg;
        logic [63:0] prod;
    } mul_t;

    // Side data carried along the divider.
    typedef struct packed {
        tc_t  tc;
        logic dx_neg;
        logic ovf;
    } div_side_t;

    // Divider to back end.
    typedef struct packed {
        tc_t         tc;
        logic        dx_neg;
        logic        ovf;
        logic [31:0] q;
    } quo_t;

    // Finished result.
    typedef struct packed {
        tc_t     tc;
        status_t status;
    } res_t;

endpackage

[hdl/tlr_in_if.sv]
// Input channel carrying one timecode per item.
interface tlr_in_if;
    logic       valid;
    logic       ready;
    logic [9:0] in_hour;
    logic [5:0] in_minute;
    logic [5:0] in_second;
    logic [9:0] in_milli;

    modport source (output valid, in_hour, in_minute, in_second, in_milli, input ready);
    modport sink (input valid, in_hour, in_minute, in_second, in_milli, output ready);
endinterface

[hdl/tlr_out_if.sv]
// Output channel carrying one remapped timecode and its status per item.
interface tlr_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [9:0] out_milli;
    logic [2:0] status;

    modport source (output valid, out_hour, out_minute, out_second, out_milli, status,
                    input ready);
    modport sink (input valid, out_hour, out_minute, out_second, out_milli, status,
                  output ready);
endinterface

[hdl/tlr_front.sv]
// Front end: timecode to milliseconds, offset from the source start, and the span product.
module tlr_front
    import tlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  tc_t  in_tc,
    input  cfg_t cfg,
    output logic out_valid,
    output mul_t out_data
);

    logic [3:0]  v_reg;
    tc_t         tc1_reg;
    tc_t         tc2_reg;
    tc_t         tc3_reg;
    logic [31:0] hour_ms_reg;
    logic [21:0] rest_ms_reg;
    logic [31:0] t_reg;
    logic        dx_neg_reg;
    logic [31:0] dx_mag_reg;
    mul_t        mul_reg;

    logic [31:0] hour_ms_next;
    logic [21:0] rest_ms_next;
    logic [31:0] t_next;
    logic [32:0] up_diff;
    logic [32:0] down_diff;
    logic        dx_neg_next;
    logic [31:0] dx_mag_next;
    logic [63:0] prod_next;

    always_comb
    begin
        hour_ms_next = 32'(in_tc.hour) * 32'(MS_PER_HOUR);
        rest_ms_next = 22'(in_tc.minute) * 22'(MS_PER_MIN)
                     + 22'(in_tc.second) * 22'(MS_PER_SEC)
                     + 22'(in_tc.milli);
        t_next       = hour_ms_reg + 32'(rest_ms_reg);
        // Both differences are formed side by side and the sign picks one.
        up_diff      = {1'b0, t_reg} - {1'b0, cfg.src_start};
        down_diff    = {1'b0, cfg.src_start} - {1'b0, t_reg};
        dx_neg_next  = up_diff[32];
        dx_mag_next  = dx_neg_next ? down_diff[31:0] : up_diff[31:0];
        prod_next    = 64'(dx_mag_reg) * 64'(cfg.dy_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tc1_reg         <= in_tc;
            hour_ms_reg     <= hour_ms_next;
            rest_ms_reg     <= rest_ms_next;
            tc2_reg         <= tc1_reg;
            t_reg           <= t_next;
            tc3_reg         <= tc2_reg;
            dx_neg_reg      <= dx_neg_next;
            dx_mag_reg      <= dx_mag_next;
            mul_reg.tc      <= tc3_reg;
            mul_reg.dx_neg  <= dx_neg_reg;
            mul_reg.prod    <= prod_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = mul_reg;

endmodule

[hdl/tlr_div.sv]
// Pipelined restoring divider: 64-bit product by the 32-bit source span, one bit per stage.
module tlr_div
    import tlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  mul_t in_data,
    input  cfg_t cfg,
    output logic out_valid,
    output quo_t out_data
);

    localparam int unsigned NST = DIV_STAGES + 1;

    logic [NST-1:0] v_reg;
    logic [31:0]    rem_reg  [NST];
    logic [31:0]    lo_reg   [NST];
    div_side_t      side_reg [NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // The upper half of the product is the starting remainder. When it already
    // reaches the divisor, the quotient does not fit in 32 bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]         <= in_data.prod[63:32];
            lo_reg[0]          <= in_data.prod[31:0];
            side_reg[0].tc     <= in_data.tc;
            side_reg[0].dx_neg <= in_data.dx_neg;
            side_reg[0].ovf    <= (in_data.prod[63:32] >= cfg.sx_mag);
        end
    end

    genvar g;
    generate
        for (g = 1; g < NST; g++)
        begin : g_step
            logic [32:0] trial;
            logic        ge;

            assign trial = {rem_reg[g-1], lo_reg[g-1][31]};
            assign ge    = (trial >= {1'b0, cfg.sx_mag});

            // The dividend bits shift out of lo at the top while quotient bits enter below.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= ge ? 32'(trial - {1'b0, cfg.sx_mag}) : trial[31:0];
                    lo_reg[g]   <= {lo_reg[g-1][30:0], ge};
                    side_reg[g] <= side_reg[g-1];
                end
            end
        end
    endgenerate

    assign out_valid       = v_reg[NST-1];
    assign out_data.tc     = side_reg[NST-1].tc;
    assign out_data.dx_neg = side_reg[NST-1].dx_neg;
    assign out_data.ovf    = side_reg[NST-1].ovf;
    assign out_data.q      = lo_reg[NST-1];

endmodule

[hdl/tlr_back.sv]
// Back end: offset onto the target span with clamping, then the split into a timecode.
module tlr_back
    import tlr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  quo_t in_data,
    input  cfg_t cfg,
    output logic out_valid,
    output res_t out_data
);

    logic [9:0]  v_reg;
    tc_t         tc_reg [9];
    status_t     st_reg [9];

    logic [31:0] r1_reg;
    logic [31:0] r2_reg;
    logic [9:0]  hest2_reg;
    logic [22:0] rem3_reg;
    logic [9:0]  hest3_reg;
    logic [9:0]  hour4_reg;
    logic [21:0] rem4_reg;
    logic [9:0]  hour5_reg;
    logic [21:0] rem5_reg;
    logic [5:0]  mest5_reg;
    logic [9:0]  hour6_reg;
    logic [16:0] rem6_reg;
    logic [5:0]  mest6_reg;
    logic [9:0]  hour7_reg;
    logic [5:0]  min7_reg;
    logic [15:0] rem7_reg;
    logic [9:0]  hour8_reg;
    logic [5:0]  min8_reg;
    logic [15:0] rem8_reg;
    logic [5:0]  sest8_reg;
    logic [9:0]  hour9_reg;
    logic [5:0]  min9_reg;
    logic [10:0] rem9_reg;
    logic [5:0]  sest9_reg;
    res_t        res_reg;

    logic        neg;
    logic [32:0] sub;
    logic [32:0] add;
    logic [31:0] r1_next;
    status_t     st_next;
    logic [42:0] hprod;
    logic [31:0] hmul;
    logic [31:0] hdiff;
    logic [9:0]  hour4_next;
    logic [21:0] rem4_next;
    logic [30:0] mprod;
    logic [21:0] mmul;
    logic [21:0] mdiff;
    logic [5:0]  min7_next;
    logic [15:0] rem7_next;
    logic [22:0] sprod;
    logic [15:0] smul;
    logic [15:0] sdiff;
    logic [5:0]  sec_next;
    logic [9:0]  milli_next;
    res_t        res_next;

    always_comb
    begin
        // A quotient of zero gives the same result on either path, so its sign can stand.
        neg = in_data.dx_neg ^ cfg.dy_neg ^ cfg.sx_neg;
        sub = {1'b0, cfg.dst_start} - {1'b0, in_data.q};
        add = {1'b0, cfg.dst_start} + {1'b0, in_data.q};
        if (cfg.pass)
        begin
            st_next = ST_PASS;
            r1_next = '0;
        end
        else if (cfg.zero_span)
        begin
            st_next = ST_ZERO_SPAN;
            r1_next = (cfg.dst_start > MAX_MS) ? MAX_MS : cfg.dst_start;
        end
        else if (neg)
        begin
            if (in_data.ovf || sub[32])
            begin
                st_next = ST_CLAMP;
                r1_next = '0;
            end
            else if (sub[31:0] > MAX_MS)
            begin
                st_next = ST_SAT;
                r1_next = MAX_MS;
            end
            else
            begin
                st_next = ST_OK;
                r1_next = sub[31:0];
            end
        end
        else
        begin
            if (in_data.ovf || (add > {1'b0, MAX_MS}))
            begin
                st_next = ST_SAT;
                r1_next = MAX_MS;
            end
            else
            begin
                st_next = ST_OK;
                r1_next = add[31:0];
            end
        end

        // Each digit: reciprocal estimate, remainder, then one correction step.
        hprod = 43'(r1_reg[31:7]) * 43'(HOUR_RECIP);
        hmul  = 32'(hest2_reg) * 32'(MS_PER_HOUR);
        hdiff = r2_reg - hmul;
        if (rem3_reg >= 23'(MS_PER_HOUR))
        begin
            hour4_next = hest3_reg + 10'd1;
            rem4_next  = 22'(rem3_reg - 23'(MS_PER_HOUR));
        end
        else
        begin
            hour4_next = hest3_reg;
            rem4_next  = rem3_reg[21:0];
        end

        mprod = 31'(rem4_reg[21:5]) * 31'(MIN_RECIP);
        mmul  = 22'(mest5_reg) * 22'(MS_PER_MIN);
        mdiff = rem5_reg - mmul;
        if (rem6_reg >= 17'(MS_PER_MIN))
        begin
            min7_next = mest6_reg + 6'd1;
            rem7_next = 16'(rem6_reg - 17'(MS_PER_MIN));
        end
        else
        begin
            min7_next = mest6_reg;
            rem7_next = rem6_reg[15:0];
        end

        sprod = 23'(rem7_reg[15:3]) * 23'(SEC_RECIP);
        smul  = 16'(sest8_reg) * 16'(MS_PER_SEC);
        sdiff = rem8_reg - smul;
        if (rem9_reg >= 11'(MS_PER_SEC))
        begin
            sec_next   = sest9_reg + 6'd1;
            milli_next = 10'(rem9_reg - 11'(MS_PER_SEC));
        end
        else
        begin
            sec_next   = sest9_reg;
            milli_next = rem9_reg[9:0];
        end

        res_next.status = st_reg[8];
        if (st_reg[8] == ST_PASS)
        begin
            res_next.tc = tc_reg[8];
        end
        else
        begin
            res_next.tc.hour   = hour9_reg;
            res_next.tc.minute = min9_reg;
            res_next.tc.second = sec_next;
            res_next.tc.milli  = milli_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tc_reg[0] <= in_data.tc;
            st_reg[0] <= st_next;
            for (int i = 1; i < 9; i++)
            begin
                tc_reg[i] <= tc_reg[i-1];
                st_reg[i] <= st_reg[i-1];
            end
            r1_reg    <= r1_next;
            r2_reg    <= r1_reg;
            hest2_reg <= hprod[41:32];
            rem3_reg  <= hdiff[22:0];
            hest3_reg <= hest2_reg;
            hour4_reg <= hour4_next;
            rem4_reg  <= rem4_next;
            hour5_reg <= hour4_reg;
            rem5_reg  <= rem4_reg;
            mest5_reg <= mprod[29:24];
            hour6_reg <= hour5_reg;
            rem6_reg  <= mdiff[16:0];
            mest6_reg <= mest5_reg;
            hour7_reg <= hour6_reg;
            min7_reg  <= min7_next;
            rem7_reg  <= rem7_next;
            hour8_reg <= hour7_reg;
            min8_reg  <= min7_reg;
            rem8_reg  <= rem7_reg;
            sest8_reg <= sprod[21:16];
            hour9_reg <= hour8_reg;
            min9_reg  <= min8_reg;
            rem9_reg  <= sdiff[10:0];
            sest9_reg <= sest8_reg;
            res_reg   <= res_next;
        end
    end

    assign out_valid = v_reg[9];
    assign out_data  = res_reg;

endmodule

[hdl/timecode_linear_remap.sv]
// Top level of the timecode linear remap block: configuration, pipeline and output buffer.
// Depth: 48 register stages from the input to the output register, which holds a result until
// it is taken.
// Throughput: one item per cycle; the 32-stage divider, one quotient bit per stage, sets the depth.
// The whole pipeline advances together and halts only while the skid register holds an item.
// Reset clears all valid bits and loads the span registers with 0, 1, 0, 1.
// Derived span values are registered and settle in the cycle after a configuration write.
module timecode_linear_remap
    import tlr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    tlr_in_if.sink           tc,
    tlr_out_if.source        res,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data
);

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_SRC_START = 2'd0;
    localparam logic [1:0] CFG_SRC_END   = 2'd1;
    localparam logic [1:0] CFG_DST_START = 2'd2;
    localparam logic [1:0] CFG_DST_END   = 2'd3;

    logic [31:0] src_start_reg;
    logic [31:0] src_end_reg;
    logic [31:0] dst_start_reg;
    logic [31:0] dst_end_reg;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    logic        en;
    tc_t         in_tc;
    logic        front_valid;
    mul_t        front_data;
    logic        div_valid;
    quo_t        div_data;
    logic        back_valid;
    res_t        back_data;
    logic        push;

    res_t        out_reg;
    logic        out_v_reg;
    logic        out_v_next;
    res_t        skid_reg;
    logic        skid_v_reg;
    logic        skid_v_next;

    // Configuration registers. The user writes only while no item is in flight; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_start_reg <= 32'd0;
            src_end_reg   <= 32'd1;
            dst_start_reg <= 32'd0;
            dst_end_reg   <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_START: src_start_reg <= cfg_data;
                CFG_SRC_END:   src_end_reg   <= cfg_data;
                CFG_DST_START: dst_start_reg <= cfg_data;
                CFG_DST_END:   dst_end_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The span signs and magnitudes are registered so that no subtract sits
    // in front of the multiplier or the divider compare.
    always_comb
    begin
        cfg_next.pass      = (dst_start_reg == dst_end_reg);
        cfg_next.zero_span = (src_start_reg == src_end_reg);
        cfg_next.dy_neg    = (dst_end_reg < dst_start_reg);
        cfg_next.dy_mag    = cfg_next.dy_neg ? dst_start_reg - dst_end_reg
                                             : dst_end_reg - dst_start_reg;
        cfg_next.sx_neg    = (src_end_reg < src_start_reg);
        cfg_next.sx_mag    = cfg_next.sx_neg ? src_start_reg - src_end_reg
                                             : src_end_reg - src_start_reg;
        cfg_next.src_start = src_start_reg;
        cfg_next.dst_start = dst_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pass: 1'b0, zero_span: 1'b0, dy_neg: 1'b0, sx_neg: 1'b0,
                         dy_mag: 32'd1, sx_mag: 32'd1, src_start: 32'd0, dst_start: 32'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The pipeline moves as long as the skid register is empty; the ready
    // seen by the source comes straight from a flip-flop.
    assign en       = !skid_v_reg;
    assign tc.ready = en;

    assign in_tc.hour   = tc.in_hour;
    assign in_tc.minute = tc.in_minute;
    assign in_tc.second = tc.in_second;
    assign in_tc.milli  = tc.in_milli;

    tlr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tc.valid),
        .in_tc     (in_tc),
        .cfg       (cfg_reg),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    tlr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .cfg       (cfg_reg),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    tlr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .cfg       (cfg_reg),
        .out_valid (back_valid),
        .out_data  (back_data)
    );

    // An item leaves the last pipeline stage whenever the pipeline moves.
    // It lands in the output register if that is free or being taken, and in
    // the skid register otherwise, which then holds the pipeline.
    assign push = en && back_valid;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        if (!out_v_reg || res.ready)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_v_next = push;
            end
        end
        else if (push)
        begin
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || res.ready)
        begin
            out_reg <= skid_v_reg ? skid_reg : back_data;
        end
        else if (push)
        begin
            skid_reg <= back_data;
        end
    end

    assign res.valid      = out_v_reg;
    assign res.out_hour   = out_reg.tc.hour;
    assign res.out_minute = out_reg.tc.minute;
    assign res.out_second = out_reg.tc.second;
    assign res.out_milli  = out_reg.tc.milli;
    assign res.status     = out_reg.status;

    // The skid register is only ever occupied behind a held output item.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register holds an item while the output register is empty");

    // The skid register fills only when the output item was stalled.
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !res.ready))
        else $error("skid register filled without an output stall");

    // A clamped result is exactly zero.
    a_clamp_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status == ST_CLAMP)) |->
        (res.out_hour == 10'd0 && res.out_minute == 6'd0 &&
         res.out_second == 6'd0 && res.out_milli == 10'd0))
        else $error("clamped result is not zero");

    // Every computed result is a well-formed timecode.
    a_digits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status != ST_PASS)) |->
        (res.out_hour < 10'd1000 && res.out_minute < 6'd60 &&
         res.out_second < 6'd60 && res.out_milli < 10'd1000))
        else $error("timecode digit out of range");

endmodule

[test/timecode_linear_remap_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the timecode linear remap block with its own predictor.
module timecode_linear_remap_tb;
    import tlr_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 8;
    // The drain wait after the last result adds margin.
    localparam int DRAIN_CYCLES = 60;
    // Longest stretch without any accepted item before the run is declared hung.
    // The long receiver hold-off below is the worst case by far.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER = 60;
    localparam int MAX_PRINTED = 40;

    // Configuration register indexes.
    localparam logic [1:0] REG_SRC_START = 2'd0;
    localparam logic [1:0] REG_SRC_END   = 2'd1;
    localparam logic [1:0] REG_DST_START = 2'd2;
    localparam logic [1:0] REG_DST_END   = 2'd3;

    // Receiver behaviors; the receiver switches between them at random.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_SRC_START;
    logic [31:0] cfg_data = '0;

    tlr_in_if  tc_if ();
    tlr_out_if res_if ();

    // All channel inputs of the block come from these variables, so they are known from time 0.
    logic drv_valid = 1'b0;
    tc_t  drv_item = '0;
    logic rcv_ready = 1'b0;

    assign tc_if.valid     = drv_valid;
    assign tc_if.in_hour   = drv_item.hour;
    assign tc_if.in_minute = drv_item.minute;
    assign tc_if.in_second = drv_item.second;
    assign tc_if.in_milli  = drv_item.milli;
    assign res_if.ready    = rcv_ready;

    timecode_linear_remap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .tc        (tc_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Local copy of the span registers, kept in step with every write to the block.
    logic [31:0] span_src_start = 32'd0;
    logic [31:0] span_src_end   = 32'd1;
    logic [31:0] span_dst_start = 32'd0;
    logic [31:0] span_dst_end   = 32'd1;

    // Timecodes waiting to be offered, and remapped results waiting to come out.
    tc_t  pending_timecodes[$];
    res_t predicted_remaps[$];

    int items_issued = 0;
    int inputs_accepted = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int stalled_cycles = 0;

    // Splits a millisecond count into a timecode, saturating at 999:59:59.999.
    function automatic tc_t ms_to_timecode(input logic [63:0] ms);
        logic [63:0] v;
        tc_t split;
        v = (ms > 64'(MAX_MS)) ? 64'(MAX_MS) : ms;
        split.hour   = 10'(v / MS_PER_HOUR);
        split.minute = 6'((v / MS_PER_MIN) % 60);
        split.second = 6'((v / MS_PER_SEC) % 60);
        split.milli  = 10'(v % MS_PER_SEC);
        return split;
    endfunction

    function automatic tc_t make_tc(input int unsigned h, input int unsigned m,
                                    input int unsigned s, input int unsigned ms);
        tc_t built;
        built.hour   = 10'(h);
        built.minute = 6'(m);
        built.second = 6'(s);
        built.milli  = 10'(ms);
        return built;
    endfunction

    // Works out the remapped timecode and status for one input timecode under the
    // current spans. The product of the two span distances is formed exactly in
    // 64 bits with the signs kept apart, and the quotient truncates toward zero.
    function automatic res_t predict_remap(input tc_t tcin);
        logic [63:0] t, dx, dy, sx, q, r;
        logic        dx_neg, dy_neg, sx_neg, neg;
        res_t        o;
        o.tc = tcin;
        o.status = ST_PASS;
        // An empty target span hands the timecode back untouched; this test comes first.
        if (span_dst_start == span_dst_end)
            return o;
        // A zero source span cannot be divided by, so the target start is returned.
        if (span_src_start == span_src_end) begin
            o.tc = ms_to_timecode(64'(span_dst_start));
            o.status = ST_ZERO_SPAN;
            return o;
        end
        // Fields above their normal range are taken at face value here.
        t = 64'(tcin.hour) * MS_PER_HOUR + 64'(tcin.minute) * MS_PER_MIN
            + 64'(tcin.second) * MS_PER_SEC + 64'(tcin.milli);
        dx_neg = t < 64'(span_src_start);
        dx = dx_neg ? 64'(span_src_start) - t : t - 64'(span_src_start);
        dy_neg = span_dst_end < span_dst_start;
        dy = dy_neg ? 64'(span_dst_start - span_dst_end) : 64'(span_dst_end - span_dst_start);
        sx_neg = span_src_end < span_src_start;
        sx = sx_neg ? 64'(span_src_start - span_src_end) : 64'(span_src_end - span_src_start);
        q = (dx * dy) / sx;
        // A quotient of zero carries no sign.
        neg = (dx_neg ^ dy_neg ^ sx_neg) && (q != 64'd0);
        if (neg) begin
            if (q > 64'(span_dst_start)) begin
                o.tc = ms_to_timecode(64'd0);
                o.status = ST_CLAMP;
                return o;
            end
            r = 64'(span_dst_start) - q;
        end else begin
            r = 64'(span_dst_start) + q;
        end
        // The quotient alone can be far beyond the timecode range, so test it before the sum.
        if ((!neg && q > 64'(MAX_MS)) || r > 64'(MAX_MS)) begin
            o.tc = ms_to_timecode(64'(MAX_MS));
            o.status = ST_SAT;
            return o;
        end
        o.tc = ms_to_timecode(r);
        o.status = ST_OK;
        return o;
    endfunction

    // Every mismatch goes through here. Only the first few are printed, all are counted.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Input and output monitor plus the watchdog. Everything is sampled at the rising
    // edge, where the block's outputs still hold the values from before the edge.
    always @(posedge clk) begin
        tc_t  arriving;
        res_t want;
        logic progress;
        if (rst_n) begin
            progress = cfg_we;
            if (tc_if.valid && tc_if.ready) begin
                arriving.hour   = tc_if.in_hour;
                arriving.minute = tc_if.in_minute;
                arriving.second = tc_if.in_second;
                arriving.milli  = tc_if.in_milli;
                predicted_remaps.insert(predicted_remaps.size(), predict_remap(arriving));
                inputs_accepted++;
                progress = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                progress = 1'b1;
                if (predicted_remaps.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no item outstanding",
                                              results_seen));
                end else begin
                    want = predicted_remaps.pop_front();
                    if (res_if.out_hour !== want.tc.hour)
                        report_mismatch($sformatf("result %0d out_hour %0d, expected %0d",
                                                  results_seen, res_if.out_hour, want.tc.hour));
                    if (res_if.out_minute !== want.tc.minute)
                        report_mismatch($sformatf("result %0d out_minute %0d, expected %0d",
                                                  results_seen, res_if.out_minute,
                                                  want.tc.minute));
                    if (res_if.out_second !== want.tc.second)
                        report_mismatch($sformatf("result %0d out_second %0d, expected %0d",
                                                  results_seen, res_if.out_second,
                                                  want.tc.second));
                    if (res_if.out_milli !== want.tc.milli)
                        report_mismatch($sformatf("result %0d out_milli %0d, expected %0d",
                                                  results_seen, res_if.out_milli, want.tc.milli));
                    if (res_if.status !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                                  results_seen, res_if.status, want.status));
                end
                results_seen++;
            end
            if (progress)
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d of %0d results seen",
                         stalled_cycles, results_seen, items_issued);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Sender. It offers items in bursts of random length separated by random gaps,
    // and holds an offered item steady until the block takes it. The monitor's
    // acceptance count tells it whether the item on the bus went in at the last edge.
    int   driver_seen = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    logic taken;
    tc_t  next_item;

    always @(negedge clk) begin
        if (rst_n) begin
            taken = (inputs_accepted != driver_seen);
            driver_seen = inputs_accepted;
            if (!drv_valid || taken) begin
                if (gap_left != 0) begin
                    drv_valid <= 1'b0;
                    gap_left--;
                end else if (pending_timecodes.size() != 0) begin
                    next_item = pending_timecodes.pop_front();
                    drv_item  <= next_item;
                    drv_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A new burst; about two times in three it follows with no gap.
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. It moves between always ready, mostly ready, rarely ready and a fixed
    // one-in-four stall. Once, early in the random part, it refuses results for a long
    // stretch while the sender keeps offering, so the pipeline fills and pushes back.
    rx_mode_t   rx_mode = RX_ALWAYS;
    int         rx_mode_left = 0;
    int         long_hold_left = 0;
    logic       long_hold_done = 1'b0;
    logic [1:0] rx_tick = 2'd0;

    always @(negedge clk) begin
        rx_tick <= rx_tick + 2'd1;
        if (long_hold_left != 0) begin
            rcv_ready <= 1'b0;
            long_hold_left--;
        end else if (!long_hold_done && inputs_accepted >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES;
            rcv_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 160);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:   rcv_ready <= 1'b1;
                RX_MOSTLY:   rcv_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE:   rcv_ready <= ($urandom_range(0, 2) == 0);
                RX_PERIODIC: rcv_ready <= (rx_tick != 2'd0);
                default:     rcv_ready <= 1'b1;
            endcase
        end
    end

    task automatic queue_timecode(input tc_t item);
        pending_timecodes.insert(pending_timecodes.size(), item);
        items_issued++;
    endtask

    // Returns once every queued item has gone in and every result has come out.
    task automatic wait_drained();
        while (inputs_accepted != items_issued || predicted_remaps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_span(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_SRC_START: span_src_start = value;
            REG_SRC_END:   span_src_end   = value;
            REG_DST_START: span_dst_start = value;
            REG_DST_END:   span_dst_end   = value;
            default:       ;
        endcase
    endtask

    // Reprograms all four spans with the block idle. The block registers its derived span
    // values after a write, so a short pause follows before new items.
    task automatic set_spans(input logic [31:0] ss, input logic [31:0] se,
                             input logic [31:0] ds, input logic [31:0] de);
        wait_drained();
        write_span(REG_SRC_START, ss);
        write_span(REG_SRC_END, se);
        write_span(REG_DST_START, ds);
        write_span(REG_DST_END, de);
        @(negedge clk);
        cfg_we <= 1'b0;
        repeat (2) @(negedge clk);
    endtask

    function automatic logic [31:0] extreme_ms();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return MAX_MS - 32'd1;
            default: return MAX_MS;
        endcase
    endfunction

    // Picks a random span setting. Half are plausible subtitle retimings, the rest
    // are reversed spans, arbitrary values and combinations of the extremes, where
    // equal values also bring up the passthrough and zero-span cases.
    task automatic choose_random_spans();
        logic [31:0] ss, se, ds, de, swap;
        case ($urandom_range(0, 5))
            0, 1, 2: begin
                ss = $urandom_range(0, 36000000);
                se = ss + $urandom_range(1000, 40000000);
                ds = $urandom_range(0, 36000000);
                de = ds + $urandom_range(1, 80000000);
                if ($urandom_range(0, 3) == 0) begin
                    swap = ds;
                    ds = de;
                    de = swap;
                end
            end
            3: begin
                ss = $urandom_range(1000, 50000000);
                se = $urandom_range(0, ss - 1);
                ds = $urandom_range(0, 50000000);
                de = $urandom_range(0, 50000000);
            end
            4: begin
                ss = $urandom_range(0, MAX_MS);
                se = $urandom_range(0, MAX_MS);
                ds = $urandom_range(0, MAX_MS);
                de = $urandom_range(0, MAX_MS);
            end
            default: begin
                ss = extreme_ms();
                se = extreme_ms();
                ds = extreme_ms();
                de = extreme_ms();
            end
        endcase
        set_spans(ss, se, ds, de);
    endtask

    // Random timecodes. One in ten uses every bit of the fields, including values
    // past the normal field ranges; two in ten are uniform legal timecodes; the
    // rest fall in or near the source span, where the interesting mapping happens.
    task automatic queue_random_items(input int count);
        logic [63:0] lo, hi, ms;
        tc_t         item;
        lo = (span_src_start < span_src_end) ? 64'(span_src_start) : 64'(span_src_end);
        hi = (span_src_start < span_src_end) ? 64'(span_src_end) : 64'(span_src_start);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       item = tc_t'($urandom);
                1, 2:    item = make_tc($urandom_range(0, 999), $urandom_range(0, 59),
                                        $urandom_range(0, 59), $urandom_range(0, 999));
                default: begin
                    ms = lo + 64'($urandom_range(0, 32'(hi - lo)));
                    case ($urandom_range(0, 4))
                        0:       ms = (ms > 64'd100000) ? ms - 64'($urandom_range(0, 100000))
                                                        : 64'd0;
                        1:       ms = ms + 64'($urandom_range(0, 100000));
                        default: ;
                    endcase
                    item = ms_to_timecode(ms);
                end
            endcase
            queue_timecode(item);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset spans map every time in range onto itself: zero, the largest timecode, the
        // largest legal fields below an hour; two times past the range saturate.
        queue_timecode(make_tc(0, 0, 0, 0));
        queue_timecode(make_tc(999, 59, 59, 999));
        queue_timecode(make_tc(0, 59, 59, 999));
        queue_timecode(make_tc(1000, 0, 0, 0));
        queue_timecode(make_tc(1023, 63, 63, 1023));

        // Empty target span: the fields come back as they went in, even all ones.
        set_spans(32'd0, 32'd1, 32'd5000, 32'd5000);
        queue_timecode(make_tc(1023, 63, 63, 1023));
        queue_timecode(make_tc(12, 34, 56, 789));

        // Zero source span: the target start comes back, first at its largest value
        // and then at zero.
        set_spans(MAX_MS, MAX_MS, MAX_MS, 32'd0);
        queue_timecode(make_tc(1, 0, 0, 0));
        set_spans(32'd1000, 32'd1000, 32'd0, 32'd7);
        queue_timecode(make_tc(5, 0, 0, 0));

        // One to two hours onto the first thousand seconds. Time zero lands below the
        // target start and is clamped; one millisecond before the span start gives a
        // quotient of zero, which must not count as negative.
        set_spans(32'd3600000, 32'd7200000, 32'd0, 32'd1000000);
        queue_timecode(make_tc(0, 0, 0, 0));
        queue_timecode(make_tc(1, 30, 0, 0));
        queue_timecode(make_tc(0, 59, 59, 999));
        queue_timecode(make_tc(3, 0, 0, 0));

        // A scale of the full range per millisecond: one millisecond lands exactly on
        // the largest timecode, two overflow the quotient itself.
        set_spans(32'd0, 32'd1, 32'd0, MAX_MS);
        queue_timecode(make_tc(0, 0, 0, 1));
        queue_timecode(make_tc(0, 0, 0, 2));

        // A small quotient that overflows only once the target start is added.
        set_spans(32'd0, 32'd1, MAX_MS - 32'd9, MAX_MS);
        queue_timecode(make_tc(0, 0, 0, 1));
        queue_timecode(make_tc(0, 0, 0, 2));

        // Both spans reversed and at full size: an identity map built from negative
        // differences, with the three signs all set at time zero.
        set_spans(MAX_MS, 32'd0, MAX_MS, 32'd0);
        queue_timecode(make_tc(0, 0, 0, 0));
        queue_timecode(make_tc(500, 0, 0, 0));
        queue_timecode(make_tc(1023, 63, 63, 1023));

        // Random part. The first phase is long enough to span the receiver hold-off.
        for (int p = 0; p < 8; p++) begin
            choose_random_spans();
            queue_random_items((p == 0) ? 200 : 120);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
